// ----- rtl/core/vinf_pkg.sv -----
// types, register codes and channel filter function for the vertical impulse noise filter
package vinf_pkg;

    localparam int PIX_W = 8;
    localparam int POS_W = 10;
    localparam int SIZE_W = 11;
    localparam int THR_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pix_t;

    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        pix_t             pix;
    } res_t;

    // replace the center by the floor average of its neighbors when it stands too high
    function automatic logic [PIX_W-1:0] filter_channel(
        input logic [PIX_W-1:0]        above,
        input logic [PIX_W-1:0]        center,
        input logic [PIX_W-1:0]        below,
        input logic signed [THR_W-1:0] thr
    );
        logic [PIX_W:0]          sum;
        logic [PIX_W-1:0]        avg;
        logic signed [PIX_W+1:0] diff;
        logic signed [PIX_W+1:0] thr_ext;
        begin
            sum = {1'b0, above} + {1'b0, below};
            avg = sum[PIX_W:1];
            diff = $signed({2'b00, center}) - $signed({2'b00, avg});
            thr_ext = {{(PIX_W+2-THR_W){thr[THR_W-1]}}, thr};
            filter_channel = (diff > thr_ext) ? avg : center;
        end
    endfunction

    function automatic pix_t filter_pixel(
        input pix_t                    above,
        input pix_t                    center,
        input pix_t                    below,
        input logic signed [THR_W-1:0] thr
    );
        pix_t f;
        begin
            f.red = filter_channel(above.red, center.red, below.red, thr);
            f.green = filter_channel(above.green, center.green, below.green, thr);
            f.blue = filter_channel(above.blue, center.blue, below.blue, thr);
            filter_pixel = f;
        end
    endfunction

endpackage

// ----- rtl/core/vertical_impulse_noise_filter_top.sv -----
// vertical 3x1 impulse noise filter over an rgb raster stream, one line memory
//
//   channel   direction  handshake              payload
//   s_axis    in         s_axis_tvalid/tready   tdata: red, green, blue
//   m_axis    out        m_axis_tvalid/tready   tdata: red, green, blue, row, column; tlast
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one pixel a cycle while the output keeps up; a pixel of the last row of a frame (from the third row on)
// yields two results and holds the input back until the second of them is taken from the output slot.
// the line memory read and the input are registered first, then the filter feeds the output register.
// the line memory holds the row above and the center row per column, read-modify-write.
// reset clears counters and handshake state and restores the configuration defaults, the line memory is not cleared.
// output stalls back up through the single pipeline stage into s_axis_tready.
module vertical_impulse_noise_filter_top
    import vinf_pkg::*;
#(
    parameter int MAX_LINE = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // in_red, in_green, in_blue
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,  // out_red, out_green, out_blue, out_row, out_column
    output logic                 m_axis_tlast,  // last_of_run
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    localparam int CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LSZ = ($clog2(MAX_LINE + 1) > SIZE_W) ? $clog2(MAX_LINE + 1) : SIZE_W;
    localparam int RSZ = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
    localparam int WORD_W = 2 * $bits(pix_t);

    // configuration
    logic signed [THR_W-1:0] thr_reg;
    logic [SIZE_W-1:0]       width_reg;
    logic [SIZE_W-1:0]       height_reg;
    logic                    restart;

    // frame position of the next pixel
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [LSZ-1:0] width_eff;
    logic [RSZ-1:0] height_eff;
    logic [LSZ-1:0] width_cfg_ext;
    logic [RSZ-1:0] height_cfg_ext;
    logic           col_wrap;
    logic           row_wrap;

    // line memory: {row above, center row}
    logic [WORD_W-1:0] line_mem [MAX_LINE];
    logic [WORD_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;

    // filter stage
    logic              s1_valid_reg;
    pix_t              s1_pix_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RW-1:0]     s1_row_reg;
    logic              s1_top_reg;
    logic              s1_filt_reg;
    logic              s1_last_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    logic              in_fire;
    logic              s1_adv;
    logic [WORD_W-1:0] s1_word;
    pix_t              above_pix;
    pix_t              center_pix;
    pix_t              filt_pix;
    logic [1:0]        res_cnt;
    res_t              res0;
    res_t              res1;
    logic [RW+POS_W-1:0] row_ext;
    logic [RW+POS_W-1:0] row_m1_ext;
    logic [CW+POS_W-1:0] col_ext;
    logic [RW-1:0]       row_m1;

    // output slots
    logic out_valid_reg;
    logic pend_reg;
    res_t slot0_reg;
    res_t slot1_reg;
    logic out_fire;
    logic out_free;

    assign cfg_ready = 1'b1;
    assign restart = cfg_valid && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
            width_reg <= SIZE_W'(1024);
            height_reg <= SIZE_W'(1024);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                CFG_WIDTH:     width_reg <= cfg_data;
                CFG_HEIGHT:    height_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // zero counts as one, oversize saturates
    always_comb
    begin
        width_cfg_ext = LSZ'(width_reg);
        height_cfg_ext = RSZ'(height_reg);
        if (width_reg == '0)
            width_eff = LSZ'(1);
        else if (width_cfg_ext > LSZ'(MAX_LINE))
            width_eff = LSZ'(MAX_LINE);
        else
            width_eff = width_cfg_ext;
        if (height_reg == '0)
            height_eff = RSZ'(1);
        else if (height_cfg_ext > RSZ'(MAX_ROWS))
            height_eff = RSZ'(MAX_ROWS);
        else
            height_eff = height_cfg_ext;
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign col_wrap = (LSZ'(col_reg) == width_eff - LSZ'(1));
    assign row_wrap = (RSZ'(row_reg) == height_eff - RSZ'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[s1_col_reg] <= wr_data;
        if (in_fire)
            rd_data_reg <= line_mem[col_reg];
    end

    // filter stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg <= pix_t'({s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[7:0]});
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
            s1_top_reg <= (row_reg == '0);
            s1_filt_reg <= (row_reg > RW'(1));
            s1_last_reg <= row_wrap;
            // same column written back at the edge it is read (single-column frames)
            fwd_hit_reg <= s1_adv && (s1_col_reg == col_reg);
            fwd_data_reg <= wr_data;
        end
    end

    assign s1_word = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign above_pix = pix_t'(s1_word[WORD_W-1:WORD_W/2]);
    assign center_pix = pix_t'(s1_word[WORD_W/2-1:0]);
    assign filt_pix = filter_pixel(above_pix, center_pix, s1_pix_reg, thr_reg);

    assign row_m1 = s1_row_reg - RW'(1);
    assign row_ext = {{POS_W{1'b0}}, s1_row_reg};
    assign row_m1_ext = {{POS_W{1'b0}}, row_m1};
    assign col_ext = {{POS_W{1'b0}}, s1_col_reg};

    always_comb
    begin
        res0.pix = s1_pix_reg;
        res0.row = row_ext[POS_W-1:0];
        res0.column = col_ext[POS_W-1:0];
        res0.last = 1'b1;
        res1 = res0;
        res_cnt = 2'd0;
        if (s1_top_reg)
        begin
            res_cnt = 2'd1;
            wr_data = {s1_pix_reg, s1_pix_reg};
        end
        else if (s1_filt_reg)
        begin
            res0.pix = filt_pix;
            res0.row = row_m1_ext[POS_W-1:0];
            res0.last = !s1_last_reg;
            res_cnt = s1_last_reg ? 2'd2 : 2'd1;
            wr_data = {filt_pix, s1_pix_reg};
        end
        else
        begin
            // second row: only kept, unless the frame ends here
            res_cnt = s1_last_reg ? 2'd1 : 2'd0;
            wr_data = {above_pix, s1_pix_reg};
        end
    end

    assign out_fire = out_valid_reg && m_axis_tready;
    assign out_free = !out_valid_reg || (out_fire && !pend_reg);
    assign s1_adv = s1_valid_reg && ((res_cnt == 2'd0) || out_free);
    assign wr_en = s1_adv;
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    // output slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (s1_adv && (res_cnt != 2'd0))
        begin
            out_valid_reg <= 1'b1;
            pend_reg <= (res_cnt == 2'd2);
        end
        else if (out_fire)
        begin
            out_valid_reg <= pend_reg;
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && (res_cnt != 2'd0))
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (out_fire && pend_reg)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {4'b0000, slot0_reg.column, slot0_reg.row,
                           slot0_reg.pix.blue, slot0_reg.pix.green, slot0_reg.pix.red};
    assign m_axis_tlast = slot0_reg.last;

endmodule

// ----- test/vertical_impulse_noise_filter_top_tb.sv -----
// self-checking testbench for the vertical impulse noise filter top level
`timescale 1ns / 100ps

module vertical_impulse_noise_filter_top_tb
    import vinf_pkg::*;
;

    localparam int LINE_LIMIT = 1024;
    localparam int ROW_LIMIT = 1024;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1450;
    localparam int QUIET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             last;
    } result_t;

    typedef enum {STEP_WRITE, STEP_PIXEL} step_kind_t;
    typedef enum {TEXTURE_SPIKES, TEXTURE_UNIFORM, TEXTURE_EXTREMES} texture_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [SIZE_W-1:0]      value;
        rgb_t                   px;
        bit                     typed;
        result_t                want;
    } directed_step_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;    // in_red, in_green, in_blue
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [47:0]          m_axis_tdata;         // out_red, out_green, out_blue, out_row, out_column
    logic                 m_axis_tlast;         // last_of_run
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    // filter state as the block should hold it
    rgb_t                    line_above [LINE_LIMIT];
    rgb_t                    line_center [LINE_LIMIT];
    int                      next_row = 0;
    int                      next_column = 0;
    logic signed [THR_W-1:0] thr_level = '0;
    logic [SIZE_W-1:0]       width_reg = 11'd1024;
    logic [SIZE_W-1:0]       height_reg = 11'd1024;

    result_t        step_out [2];
    result_t        awaited_pixels [$];
    directed_step_t directed_steps [$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             stall_mode = 0;
    int             stall_left = 0;
    int             stall_tick = 0;

    vertical_impulse_noise_filter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic rgb_t rgb(int r, int g, int b);
        rgb_t p;
        begin
            p.red = PIX_W'(r);
            p.green = PIX_W'(g);
            p.blue = PIX_W'(b);
            return p;
        end
    endfunction

    function automatic result_t pack_result(rgb_t px, int row, int col, bit last);
        result_t res;
        begin
            res.red = px.red;
            res.green = px.green;
            res.blue = px.blue;
            res.row = POS_W'(row);
            res.column = POS_W'(col);
            res.last = last;
            return res;
        end
    endfunction

    function automatic int clamp_size(logic [SIZE_W-1:0] v, int limit);
        begin
            if (v == 0)
                return 1;
            if (v > limit)
                return limit;
            return v;
        end
    endfunction

    function automatic logic [PIX_W-1:0] smooth_channel(logic [PIX_W-1:0] above,
                                                        logic [PIX_W-1:0] center,
                                                        logic [PIX_W-1:0] below);
        int avg;
        begin
            avg = (int'(above) + int'(below)) / 2;
            if (int'(center) - avg > int'(thr_level))
                return PIX_W'(avg);
            return center;
        end
    endfunction

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        begin
            case (idx)
                CFG_THRESHOLD: thr_level = value[THR_W-1:0];
                CFG_WIDTH:
                begin
                    width_reg = value;
                    next_row = 0;
                    next_column = 0;
                end
                CFG_HEIGHT:
                begin
                    height_reg = value;
                    next_row = 0;
                    next_column = 0;
                end
                default: ;
            endcase
        end
    endtask

    // fills step_out with the finished pixels one input pixel releases
    task automatic predict_filtered_pixels(input rgb_t px, output int n);
        int   w;
        int   h;
        int   r;
        int   c;
        rgb_t f;
        begin
            w = clamp_size(width_reg, LINE_LIMIT);
            h = clamp_size(height_reg, ROW_LIMIT);
            r = next_row;
            c = next_column;
            n = 0;
            if (c >= w)
                c = 0;
            if (r >= h)
                r = 0;
            if (r == 0)
            begin
                step_out[n] = pack_result(px, r, c, 1'b0);
                n++;
                line_above[c] = px;
            end
            else
            begin
                if (r >= 2)
                begin
                    f.red = smooth_channel(line_above[c].red, line_center[c].red, px.red);
                    f.green = smooth_channel(line_above[c].green, line_center[c].green,
                                             px.green);
                    f.blue = smooth_channel(line_above[c].blue, line_center[c].blue, px.blue);
                    step_out[n] = pack_result(f, r - 1, c, 1'b0);
                    n++;
                    line_above[c] = f;
                end
                line_center[c] = px;
                if (r == h - 1)
                begin
                    step_out[n] = pack_result(px, r, c, 1'b0);
                    n++;
                end
            end
            if (n > 0)
                step_out[n-1].last = 1'b1;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
            next_row = r;
            next_column = c;
        end
    endtask

    task automatic send_pixel(rgb_t px, bit typed, result_t want);
        int n;
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {px.blue, px.green, px.red};
            do @(posedge clk); while (!s_axis_tready);
            predict_filtered_pixels(px, n);
            if (typed)
                awaited_pixels.push_back(want);
            else
                for (int k = 0; k < n; k++)
                    awaited_pixels.push_back(step_out[k]);
        end
    endtask

    task automatic pause_input(int cycles);
        begin
            repeat (cycles)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                s_axis_tdata <= 24'($urandom);
            end
        end
    endtask

    // hold the input until every result is out and second-row pixels have left the pipe
    task automatic settle();
        begin
            pause_input(1);
            while (awaited_pixels.size() != 0)
                @(posedge clk);
            repeat (QUIET_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            do @(posedge clk); while (!cfg_ready);
            apply_register(idx, value);
            @(negedge clk);
            cfg_valid <= 1'b0;
            cfg_data <= SIZE_W'($urandom);
        end
    endtask

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        directed_step_t s;
        begin
            s.kind = STEP_WRITE;
            s.index = idx;
            s.value = value;
            s.typed = 1'b0;
            directed_steps.push_back(s);
        end
    endfunction

    function automatic void add_pixel(rgb_t px, bit typed, int row, int col);
        directed_step_t s;
        begin
            s.kind = STEP_PIXEL;
            s.px = px;
            s.typed = typed;
            s.want = pack_result(px, row, col, 1'b1);
            directed_steps.push_back(s);
        end
    endfunction

    function automatic logic [PIX_W-1:0] texture_channel(texture_kind_t texture,
                                                         logic [PIX_W-1:0] base);
        int v;
        begin
            case (texture)
                TEXTURE_SPIKES:
                begin
                    if ($urandom_range(0, 5) == 0)
                        return PIX_W'($urandom_range(200, 255));
                    v = int'(base) + $urandom_range(0, 24) - 12;
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    return PIX_W'(v);
                end
                TEXTURE_UNIFORM: return PIX_W'($urandom);
                default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
        end
    endfunction

    function automatic int pick_size();
        begin
            case ($urandom_range(0, 19))
                0: return 0;
                1: return $urandom_range(1025, 2047);
                2: return 1024;
                3: return $urandom_range(100, 1023);
                default: return $urandom_range(1, 6);
            endcase
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        begin
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                error_count++;
            end
        end
    endfunction

    // receiver stalls: always ready, coin flip, one in four, or rare drops
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) != 0);
            2: m_axis_tready <= (stall_tick % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_pixels.size() == 0)
            begin
                $error("result with no request pending: tdata %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                check_field("out_red", awaited_pixels[0].red, m_axis_tdata[7:0]);
                check_field("out_green", awaited_pixels[0].green, m_axis_tdata[15:8]);
                check_field("out_blue", awaited_pixels[0].blue, m_axis_tdata[23:16]);
                check_field("out_row", awaited_pixels[0].row, m_axis_tdata[33:24]);
                check_field("out_column", awaited_pixels[0].column, m_axis_tdata[43:34]);
                check_field("last_of_run", awaited_pixels[0].last, m_axis_tlast);
                void'(awaited_pixels.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** vertical_impulse_noise_filter_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int                      random_pixels;
        int                      count;
        int                      w_eff;
        int                      h_eff;
        int                      burst_left;
        bit                      drained_once;
        bit                      tall_done;
        logic [1:0]              spare;
        logic signed [THR_W-1:0] thr_pick;
        texture_kind_t           texture;
        rgb_t                    base;
        result_t                 no_result;

        random_pixels = 0;
        burst_left = 0;
        drained_once = 1'b0;
        tall_done = 1'b0;
        no_result = '0;
        for (int k = 0; k < LINE_LIMIT; k++)
        begin
            line_above[k] = '0;
            line_center[k] = '0;
        end

        // power-up sizes: first row passes straight through
        add_pixel(rgb(12, 34, 56), 1'b1, 0, 0);
        add_pixel(rgb(200, 1, 255), 1'b1, 0, 1);
        // zero width reads as one, single row frame
        add_write(CFG_WIDTH, 11'd0);
        add_write(CFG_HEIGHT, 11'd1);
        add_pixel(rgb(0, 0, 0), 1'b1, 0, 0);
        add_pixel(rgb(255, 255, 255), 1'b1, 0, 0);
        add_pixel(rgb(8'hAA, 8'h55, 8'h5A), 1'b1, 0, 0);
        // unknown index leaves everything alone
        add_write(CFG_UNUSED, 11'h7FF);
        add_pixel(rgb(1, 2, 3), 1'b1, 0, 0);
        add_write(CFG_HEIGHT, 11'd0);
        add_pixel(rgb(128, 127, 129), 1'b1, 0, 0);
        // three rows, replace on any positive jump
        add_write(CFG_WIDTH, 11'd2);
        add_write(CFG_HEIGHT, 11'd3);
        add_write(CFG_THRESHOLD, 11'd0);
        add_pixel(rgb(0, 0, 0), 1'b0, 0, 0);
        add_pixel(rgb(255, 255, 255), 1'b0, 0, 0);
        add_pixel(rgb(255, 255, 255), 1'b0, 0, 0);
        add_pixel(rgb(0, 10, 20), 1'b0, 0, 0);
        add_pixel(rgb(0, 0, 0), 1'b0, 0, 0);
        add_pixel(rgb(255, 254, 253), 1'b0, 0, 0);
        // most negative threshold: replaces even dark centers
        add_write(CFG_THRESHOLD, 11'h100);
        add_pixel(rgb(100, 100, 100), 1'b0, 0, 0);
        add_pixel(rgb(50, 60, 70), 1'b0, 0, 0);
        add_pixel(rgb(10, 200, 90), 1'b0, 0, 0);
        add_pixel(rgb(60, 60, 60), 1'b0, 0, 0);
        add_pixel(rgb(100, 100, 100), 1'b0, 0, 0);
        add_pixel(rgb(255, 0, 128), 1'b0, 0, 0);
        // two row frame, highest threshold, then oversize width saturates
        add_write(CFG_THRESHOLD, 11'h0FF);
        add_write(CFG_HEIGHT, 11'd2);
        add_pixel(rgb(255, 0, 255), 1'b0, 0, 0);
        add_pixel(rgb(0, 255, 0), 1'b0, 0, 0);
        add_pixel(rgb(7, 8, 9), 1'b0, 0, 0);
        add_pixel(rgb(250, 251, 252), 1'b0, 0, 0);
        add_write(CFG_WIDTH, 11'h7FF);
        add_pixel(rgb(31, 63, 127), 1'b1, 0, 0);
        add_pixel(rgb(128, 192, 224), 1'b1, 0, 1);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_WRITE)
            begin
                settle();
                write_register(directed_steps[i].index, directed_steps[i].value);
            end
            else
                send_pixel(directed_steps[i].px, directed_steps[i].typed,
                           directed_steps[i].want);
        end

        while (random_pixels < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 7))
                0: thr_pick = THR_W'(-256);
                1: thr_pick = THR_W'(255);
                2: thr_pick = '0;
                3: thr_pick = THR_W'($urandom);
                default: thr_pick = THR_W'(int'($urandom_range(0, 100)) - 40);
            endcase
            spare = 2'($urandom);
            write_register(CFG_THRESHOLD, {spare, thr_pick});
            if (!tall_done)
            begin
                // one tall single-column frame to reach the high row numbers
                write_register(CFG_WIDTH, 11'd1);
                write_register(CFG_HEIGHT, 11'h7FF);
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 1))
                begin
                    write_register(CFG_WIDTH, SIZE_W'(pick_size()));
                    write_register(CFG_HEIGHT, SIZE_W'(pick_size()));
                end
                else
                begin
                    write_register(CFG_HEIGHT, SIZE_W'(pick_size()));
                    write_register(CFG_WIDTH, SIZE_W'(pick_size()));
                end
                if ($urandom_range(0, 5) == 0)
                    write_register(CFG_UNUSED, SIZE_W'($urandom));
            end
            w_eff = clamp_size(width_reg, LINE_LIMIT);
            h_eff = clamp_size(height_reg, ROW_LIMIT);
            if (!tall_done)
                count = $urandom_range(520, 560);
            else if (w_eff * h_eff <= 48)
            begin
                count = w_eff * h_eff * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    count += $urandom_range(0, w_eff - 1);
            end
            else
                count = $urandom_range(8, 60);
            tall_done = 1'b1;

            case ($urandom_range(0, 9))
                0: texture = TEXTURE_EXTREMES;
                1, 2, 3: texture = TEXTURE_UNIFORM;
                default: texture = TEXTURE_SPIKES;
            endcase
            base = 24'($urandom);

            repeat (count)
            begin
                if (burst_left == 0)
                begin
                    if (!drained_once || $urandom_range(0, 39) == 0)
                    begin
                        settle();
                        drained_once = 1'b1;
                    end
                    else
                        pause_input($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                              : $urandom_range(1, 16);
                end
                burst_left--;
                send_pixel(rgb(texture_channel(texture, base.red),
                               texture_channel(texture, base.green),
                               texture_channel(texture, base.blue)), 1'b0, no_result);
                random_pixels++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && awaited_pixels.size() == 0)
            $display("** vertical_impulse_noise_filter_top: PASSED **");
        else
            $display("** vertical_impulse_noise_filter_top: FAILED **");
        $finish;
    end

endmodule

// ----- vertical_impulse_noise_filter_top.f -----
rtl/core/vinf_pkg.sv
rtl/core/vertical_impulse_noise_filter_top.sv
test/vertical_impulse_noise_filter_top_tb.sv
